>>> rtl/core/pfar_pkg.sv
// Package of the page frame allocator: field widths, request and status codes,
// payload structs, back-end state type. Used by rtl/core files but pfar_ram.
package pfar_pkg;

  // Fixed field widths of the request, result and configuration items
  localparam int PAGE_W      = 16;
  localparam int COUNT_OUT_W = 8;
  localparam int FREE_W      = 17;
  localparam int LOW_W       = 16;
  localparam int TOP_W       = 17;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 17;

  // Defaults for the top-level parameters
  localparam int DEF_NUM_PAGES   = 65536;
  localparam int DEF_COUNT_WIDTH = 8;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [LOW_W-1:0] LOW_RESET = 16'h0000;
  localparam logic [TOP_W-1:0] TOP_RESET = 17'h10000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PAGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_PAGE = 1'b1;

  typedef enum logic [2:0] {
    REQ_INIT  = 3'd0,
    REQ_ALLOC = 3'd1,
    REQ_FREE  = 3'd2,
    REQ_INCR  = 3'd3,
    REQ_DECR  = 3'd4,
    REQ_GET   = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_NO_FREE = 3'd1,
    STAT_OOB     = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_SAT     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  // Request item as it arrives
  typedef struct packed {
    logic [2:0]        req_type;
    logic [PAGE_W-1:0] page;
  } req_t;

  // Result item
  typedef struct packed {
    status_e                status;
    logic [PAGE_W-1:0]      page_out;
    logic [COUNT_OUT_W-1:0] count_out;
    logic                   page_released;
    logic [FREE_W-1:0]      free_pages;
  } res_t;

  // Classified request held in the queue
  typedef struct packed {
    req_e              op;
    logic [PAGE_W-1:0] page;
    logic              outside;    // page beyond the count store
    logic              bound_bad;  // page outside [low_page, top_page)
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/core/pfar_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/pfar_queue.sv
// Short command queue between the front and back of the page allocator.
// Depends on pfar_pkg.
module pfar_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pfar_pkg::cmd_t   cmd_i,
  input  logic             pop_i,
  output pfar_pkg::cmd_t   cmd_o,
  output pfar_pkg::q_stat_t stat_o
);

  localparam int Depth = pfar_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  pfar_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // pointer and fill updates
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = entry_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> rtl/core/pfar_front.sv
// Front end of the page allocator: configuration registers, request intake
// and classification into queue commands. Depends on pfar_pkg.
module pfar_front #(
  parameter int NUM_PAGES = pfar_pkg::DEF_NUM_PAGES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfar_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfar_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  pfar_pkg::req_t                  in_data_i,
  output logic                            in_stall_o,
  input  pfar_pkg::q_stat_t               q_stat_i,
  input  logic                            clearing_i,
  output logic                            push_o,
  output pfar_pkg::cmd_t                  cmd_o
);

  logic [pfar_pkg::LOW_W-1:0] low_q, low_d;
  logic [pfar_pkg::TOP_W-1:0] top_q, top_d;

  // register writes
  always_comb begin
    low_d = low_q;
    top_d = top_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfar_pkg::CFG_LOW_PAGE: low_d = cfg_wdata_i[pfar_pkg::LOW_W-1:0];
        pfar_pkg::CFG_TOP_PAGE: top_d = cfg_wdata_i[pfar_pkg::TOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q <= pfar_pkg::LOW_RESET;
      top_q <= pfar_pkg::TOP_RESET;
    end else begin
      low_q <= low_d;
      top_q <= top_d;
    end
  end

  // intake: hold off while the queue is full or the count store is clearing
  assign in_stall_o = q_stat_i.full || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // classification; unused codes act as get
  always_comb begin
    if (in_data_i.req_type > pfar_pkg::REQ_GET) begin
      cmd_o.op = pfar_pkg::REQ_GET;
    end else begin
      cmd_o.op = pfar_pkg::req_e'(in_data_i.req_type);
    end
    cmd_o.page      = in_data_i.page;
    cmd_o.outside   = (32'(in_data_i.page) >= 32'(NUM_PAGES));
    cmd_o.bound_bad = (in_data_i.page < low_q) ||
                      ({1'b0, in_data_i.page} >= top_q);
  end

endmodule

>>> rtl/core/pfar_back.sv
// Back end of the page allocator: free-page stack, reference count store,
// clearing pass after reset and the result register.
// Depends on pfar_pkg and pfar_ram.
module pfar_back #(
  parameter int NUM_PAGES   = pfar_pkg::DEF_NUM_PAGES,
  parameter int COUNT_WIDTH = pfar_pkg::DEF_COUNT_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfar_pkg::q_stat_t q_stat_i,
  input  pfar_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  output logic              clearing_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfar_pkg::res_t    out_data_o
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int DW = $clog2(NUM_PAGES + 1);
  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CountMax = {CW{1'b1}};

  pfar_pkg::state_e state_q, state_d;
  logic [PW-1:0]    clr_q, clr_d;
  logic [DW-1:0]    depth_q, depth_d;
  logic             out_valid_q, out_valid_d;
  pfar_pkg::cmd_t   cmd_q;
  pfar_pkg::res_t   res_q, res_d;

  logic                      slot_free;
  logic                      fire;
  logic                      rd_en;
  logic                      cnt_we;
  logic [PW-1:0]             cnt_waddr;
  logic [CW-1:0]             cnt_wdata;
  logic [CW-1:0]             cnt_rd;
  logic                      stk_we;
  logic [pfar_pkg::PAGE_W-1:0] stk_rd;

  // count store and free-page stack
  pfar_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_PAGES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (rd_en),
    .raddr_i (PW'(cmd_i.page)),
    .rdata_o (cnt_rd)
  );

  pfar_ram #(
    .WIDTH (pfar_pkg::PAGE_W),
    .DEPTH (NUM_PAGES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (PW'(depth_q)),
    .wdata_i (cmd_q.page),
    .re_i    (rd_en),
    .raddr_i (PW'(depth_q - DW'(1))),
    .rdata_o (stk_rd)
  );

  assign slot_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      pfar_pkg::S_CLEAR: begin
        clr_d = clr_q + PW'(1);
        if (clr_q == PW'(NUM_PAGES - 1)) begin
          state_d = pfar_pkg::S_IDLE;
        end
      end
      pfar_pkg::S_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = pfar_pkg::S_EXEC;
        end
      end
      pfar_pkg::S_EXEC: begin
        if (slot_free) begin
          state_d = pfar_pkg::S_IDLE;
        end
      end
      default: state_d = pfar_pkg::S_IDLE;
    endcase
  end

  // outputs: memory control and request execution
  always_comb begin
    logic          want_cnt_we;
    logic [CW-1:0] new_cnt;

    want_cnt_we = 1'b0;
    new_cnt     = '0;
    stk_we      = 1'b0;
    rd_en       = 1'b0;
    cmd_pop_o   = 1'b0;
    fire        = 1'b0;
    cnt_waddr   = PW'(cmd_q.page);
    depth_d     = depth_q;

    res_d.status        = pfar_pkg::STAT_OK;
    res_d.page_out      = cmd_q.page;
    res_d.count_out     = '0;
    res_d.page_released = 1'b0;
    res_d.free_pages    = '0;

    unique case (state_q)
      pfar_pkg::S_IDLE: begin
        cmd_pop_o = !q_stat_i.empty;
        rd_en     = !q_stat_i.empty;
      end
      pfar_pkg::S_EXEC: fire = slot_free;
      default: ;
    endcase

    if (cmd_q.op == pfar_pkg::REQ_ALLOC) begin
      if (depth_q == '0) begin
        res_d.status   = pfar_pkg::STAT_NO_FREE;
        res_d.page_out = '0;
      end else begin
        depth_d        = depth_q - DW'(1);
        res_d.page_out = stk_rd;
        cnt_waddr      = PW'(stk_rd);
        new_cnt        = CW'(1);
        want_cnt_we    = 1'b1;
      end
    end else if (cmd_q.outside) begin
      res_d.status = pfar_pkg::STAT_OOB;
    end else begin
      unique case (cmd_q.op) inside
        pfar_pkg::REQ_INIT, pfar_pkg::REQ_FREE: begin
          if (cmd_q.bound_bad) begin
            res_d.status = pfar_pkg::STAT_OOB;
            new_cnt      = cnt_rd;
          end else begin
            want_cnt_we = 1'b1;
            if (cmd_q.op == pfar_pkg::REQ_FREE && cnt_rd != '0) begin
              new_cnt = cnt_rd - CW'(1);
            end
            if (new_cnt == '0) begin
              if (depth_q == DW'(NUM_PAGES)) begin
                res_d.status = pfar_pkg::STAT_FULL;
              end else begin
                stk_we              = fire;
                depth_d             = depth_q + DW'(1);
                res_d.page_released = 1'b1;
              end
            end
          end
        end
        pfar_pkg::REQ_INCR: begin
          want_cnt_we = 1'b1;
          if (cnt_rd == CountMax) begin
            res_d.status = pfar_pkg::STAT_SAT;
            new_cnt      = cnt_rd;
          end else begin
            new_cnt = cnt_rd + CW'(1);
          end
        end
        pfar_pkg::REQ_DECR: begin
          want_cnt_we = 1'b1;
          if (cnt_rd == '0) begin
            res_d.status = pfar_pkg::STAT_SAT;
            new_cnt      = cnt_rd;
          end else begin
            new_cnt = cnt_rd - CW'(1);
          end
        end
        default: new_cnt = cnt_rd;
      endcase
    end

    res_d.count_out  = pfar_pkg::COUNT_OUT_W'(new_cnt);
    res_d.free_pages = pfar_pkg::FREE_W'(depth_d);

    // clearing pass owns the count write port
    if (state_q == pfar_pkg::S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = '0;
    end else begin
      cnt_we    = fire && want_cnt_we;
      cnt_wdata = new_cnt;
    end
  end

  // result register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfar_pkg::S_CLEAR;
      clr_q       <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        depth_q <= depth_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign clearing_o  = (state_q == pfar_pkg::S_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // the stack never holds more than every page
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(NUM_PAGES))
    else $error("free stack depth beyond page count");

  // a push only happens with room on the stack
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we |-> (depth_q < DW'(NUM_PAGES)))
    else $error("push onto a full stack");

  // commands are taken only when idle and the queue has one
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == pfar_pkg::S_IDLE && !q_stat_i.empty))
    else $error("queue pop outside idle");

  // a finished request always shows up as a valid result
  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("result lost after execution");

endmodule

>>> rtl/core/page_frame_allocator_refcount.sv
// Top level of the page frame allocator with per-page reference counts.
// Depends on pfar_pkg, pfar_front, pfar_queue, pfar_back and pfar_ram.
//
// Usage:
//   Requests enter on in_valid_i / in_data_i and are taken at a clock edge
//   where in_valid_i is high and in_stall_o is low. Each request gives one
//   result on out_valid_o / out_data_o, taken where out_stall_i is low.
//   low_page (index 0) and top_page (index 1) are to be written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i only while the block is idle; it does not enforce this.
//   Path: a taken request goes into the queue, then into the back end's
//   command register as its count and stack entries are read, then into the
//   result register once that is free. The back end takes no new request
//   before the last is executed: the count memory's registered read comes
//   before the count write of the same request. A two-entry queue lets the
//   front take requests while the back end works or the result waits.
//   Reset: the free stack is emptied and the count memory is cleared by a
//   pass over all NUM_PAGES entries, one entry per cycle, during which
//   in_stall_o stays high. Configuration writes are taken during the pass.
//   Receiver stall: the result register holds; the back end waits, then the
//   queue fills and in_stall_o rises.
module page_frame_allocator_refcount #(
  parameter int NUM_PAGES   = pfar_pkg::DEF_NUM_PAGES,
  parameter int COUNT_WIDTH = pfar_pkg::DEF_COUNT_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfar_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfar_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pfar_pkg::req_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pfar_pkg::res_t                  out_data_o
);

  pfar_pkg::q_stat_t q_stat;
  pfar_pkg::cmd_t    push_cmd;
  pfar_pkg::cmd_t    head_cmd;
  logic              push;
  logic              pop;
  logic              clearing;

  // intake and classification
  pfar_front #(
    .NUM_PAGES (NUM_PAGES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .q_stat_i    (q_stat),
    .clearing_i  (clearing),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // command queue
  pfar_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  // execution
  pfar_back #(
    .NUM_PAGES   (NUM_PAGES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> sim/pfar_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the page frame allocator: keeps its own free stack,
// reference counts and bounds, predicts every result and compares it with
// the block's output. Depends on pfar_pkg.
module pfar_result_checker #(
  parameter int PAGES   = pfar_pkg::DEF_NUM_PAGES,
  parameter int COUNT_W = pfar_pkg::DEF_COUNT_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfar_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfar_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  pfar_pkg::req_t                  in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  pfar_pkg::res_t                  out_data_i,
  output int                              mismatch_count_o,
  output int                              pending_o
);

  localparam int unsigned COUNT_MAX = 32'((64'd1 << COUNT_W) - 64'd1);
  localparam int          REPORT_MAX = 10;

  // Mirror of the allocator state
  logic [pfar_pkg::PAGE_W-1:0] free_stack [PAGES];
  int unsigned                 ref_counts [PAGES];
  int unsigned                 stack_depth;
  int unsigned                 low_page;
  int unsigned                 top_page;

  pfar_pkg::res_t expected_results [$];
  pfar_pkg::res_t want;
  int             mismatches;

  // Apply one request to the mirror and return the result it must give
  function automatic pfar_pkg::res_t apply_request(pfar_pkg::req_t item);
    pfar_pkg::res_t res;
    int unsigned    pg;
    pg                = 32'(item.page);
    res.status        = pfar_pkg::STAT_OK;
    res.page_out      = item.page;
    res.count_out     = '0;
    res.page_released = 1'b0;
    if (item.req_type == pfar_pkg::REQ_ALLOC) begin
      if (stack_depth == 0) begin
        res.status   = pfar_pkg::STAT_NO_FREE;
        res.page_out = '0;
      end else begin
        stack_depth--;
        res.page_out             = free_stack[stack_depth];
        ref_counts[res.page_out] = 1;
        res.count_out            = pfar_pkg::COUNT_OUT_W'(1);
      end
    end else if (pg >= PAGES) begin
      res.status = pfar_pkg::STAT_OOB;
    end else if (item.req_type == pfar_pkg::REQ_INIT ||
                 item.req_type == pfar_pkg::REQ_FREE) begin
      if (pg < low_page || pg >= top_page) begin
        res.status    = pfar_pkg::STAT_OOB;
        res.count_out = pfar_pkg::COUNT_OUT_W'(ref_counts[pg]);
      end else begin
        if (item.req_type == pfar_pkg::REQ_INIT) ref_counts[pg] = 0;
        else if (ref_counts[pg] != 0) ref_counts[pg]--;
        res.count_out = pfar_pkg::COUNT_OUT_W'(ref_counts[pg]);
        // count at zero: page goes back on the stack if there is room
        if (ref_counts[pg] == 0) begin
          if (stack_depth < PAGES) begin
            free_stack[stack_depth] = item.page;
            stack_depth++;
            res.page_released = 1'b1;
          end else begin
            res.status = pfar_pkg::STAT_FULL;
          end
        end
      end
    end else if (item.req_type == pfar_pkg::REQ_INCR) begin
      if (ref_counts[pg] >= COUNT_MAX) res.status = pfar_pkg::STAT_SAT;
      else ref_counts[pg]++;
      res.count_out = pfar_pkg::COUNT_OUT_W'(ref_counts[pg]);
    end else if (item.req_type == pfar_pkg::REQ_DECR) begin
      if (ref_counts[pg] == 0) res.status = pfar_pkg::STAT_SAT;
      else ref_counts[pg]--;
      res.count_out = pfar_pkg::COUNT_OUT_W'(ref_counts[pg]);
    end else begin
      // get, and the two unused codes
      res.count_out = pfar_pkg::COUNT_OUT_W'(ref_counts[pg]);
    end
    res.free_pages = pfar_pkg::FREE_W'(stack_depth);
    return res;
  endfunction

  // Watch both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_page    = 32'(pfar_pkg::LOW_RESET);
      top_page    = 32'(pfar_pkg::TOP_RESET);
      stack_depth = 0;
      for (int i = 0; i < PAGES; i++) ref_counts[i] = 0;
      expected_results.delete();
      mismatches       = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      // results first: a result never belongs to an item taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result item with none expected: status %0d page %h",
                     $realtime, out_data_i.status, out_data_i.page_out);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.status !== want.status ||
              out_data_i.page_out !== want.page_out ||
              out_data_i.count_out !== want.count_out ||
              out_data_i.page_released !== want.page_released ||
              out_data_i.free_pages !== want.free_pages) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: result mismatch: expected status %0d page %h count %0d",
                       $realtime, want.status, want.page_out, want.count_out,
                       " rel %0b free %0d, got status %0d page %h",
                       want.page_released, want.free_pages, out_data_i.status,
                       out_data_i.page_out,
                       " count %0d rel %0b free %0d", out_data_i.count_out,
                       out_data_i.page_released, out_data_i.free_pages);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(apply_request(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pfar_pkg::CFG_LOW_PAGE: low_page = 32'(cfg_wdata_i[pfar_pkg::LOW_W-1:0]);
          pfar_pkg::CFG_TOP_PAGE: top_page = 32'(cfg_wdata_i[pfar_pkg::TOP_W-1:0]);
          default: ;
        endcase
      end
      pending_o        <= expected_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

>>> sim/tb_page_frame_allocator_refcount.sv
`timescale 1ns / 100ps
// Testbench top of the page frame allocator: drives requests, bounds and
// receiver stalls, and gives the verdict. Depends on pfar_pkg, the block
// and pfar_result_checker.
module tb_page_frame_allocator_refcount;

  localparam int PAGES          = pfar_pkg::DEF_NUM_PAGES;
  localparam int WATCHDOG_LIMIT = 4 * PAGES;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PAGE_W         = pfar_pkg::PAGE_W;
  localparam int CFG_DATA_W     = pfar_pkg::CFG_DATA_W;

  // unused request codes, handled as get
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               cfg_we    = 1'b0;
  logic [pfar_pkg::CFG_IDX_W-1:0]     cfg_idx   = pfar_pkg::CFG_LOW_PAGE;
  logic [CFG_DATA_W-1:0]              cfg_wdata = '0;
  logic                               in_valid  = 1'b0;
  logic                               in_stall;
  pfar_pkg::req_t                     in_data   = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  pfar_pkg::res_t                     out_data;

  int mismatches;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  page_frame_allocator_refcount u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pfar_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles without any item moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request and hold it until taken
  task automatic send_req(input logic [2:0] kind, input logic [PAGE_W-1:0] pg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data.req_type <= kind;
    in_data.page     <= pg;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Stop sending and wait until every result is in
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both bound registers, back to back
  task automatic set_bounds(input logic [pfar_pkg::LOW_W-1:0] low,
                            input logic [pfar_pkg::TOP_W-1:0] top);
    cfg_we    <= 1'b1;
    cfg_idx   <= pfar_pkg::CFG_LOW_PAGE;
    cfg_wdata <= CFG_DATA_W'(low);
    @(posedge clk);
    cfg_idx   <= pfar_pkg::CFG_TOP_PAGE;
    cfg_wdata <= CFG_DATA_W'(top);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random mix around a window of pages, with whole page lifetimes
  task automatic run_mixed(input int n, input logic [PAGE_W-1:0] base);
    int                sent;
    int                pick;
    int                reps;
    logic [PAGE_W-1:0] pg;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) pg = PAGE_W'($urandom);
      else pg = base + PAGE_W'($urandom_range(47));
      if (pick < 20) begin
        // page returned, taken, shared a few times, then released
        reps = $urandom_range(3);
        send_req(pfar_pkg::REQ_INIT, pg);
        send_req(pfar_pkg::REQ_ALLOC, PAGE_W'($urandom));
        repeat (reps) send_req(pfar_pkg::REQ_INCR, pg);
        repeat (reps + 1) send_req(pfar_pkg::REQ_FREE, pg);
        sent += 2 * reps + 3;
      end else begin
        if (pick < 32) send_req(pfar_pkg::REQ_INIT, pg);
        else if (pick < 50) send_req(pfar_pkg::REQ_ALLOC, pg);
        else if (pick < 66) send_req(pfar_pkg::REQ_FREE, pg);
        else if (pick < 78) send_req(pfar_pkg::REQ_INCR, pg);
        else if (pick < 88) send_req(pfar_pkg::REQ_DECR, pg);
        else if (pick < 96) send_req(pfar_pkg::REQ_GET, pg);
        else if (pick < 98) send_req(REQ_SPARE_6, pg);
        else send_req(REQ_SPARE_7, pg);
        sent++;
      end
    end
  endtask

  initial begin
    logic [PAGE_W-1:0] sat_page;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // bounds go in during the clearing pass
    send_idle_pct  = 24;
    recv_stall_pct = 57;
    set_bounds(16'd4, 17'd256);

    // directed: empty stack, bounds edges, counts, re-push, spare codes
    send_req(pfar_pkg::REQ_ALLOC, 16'h0000);
    send_req(pfar_pkg::REQ_GET, 16'hFFFF);
    send_req(pfar_pkg::REQ_INCR, 16'hFFFF);
    send_req(pfar_pkg::REQ_INIT, 16'd3);
    send_req(pfar_pkg::REQ_INIT, 16'd256);
    send_req(pfar_pkg::REQ_INIT, 16'd255);
    send_req(pfar_pkg::REQ_INIT, 16'd4);
    send_req(pfar_pkg::REQ_ALLOC, 16'h0000);
    send_req(pfar_pkg::REQ_ALLOC, 16'hFFFF);
    send_req(pfar_pkg::REQ_ALLOC, 16'h0000);
    send_req(pfar_pkg::REQ_INCR, 16'd4);
    send_req(pfar_pkg::REQ_FREE, 16'd4);
    send_req(pfar_pkg::REQ_FREE, 16'd4);
    send_req(pfar_pkg::REQ_FREE, 16'd4);
    send_req(pfar_pkg::REQ_DECR, 16'd10);
    send_req(pfar_pkg::REQ_DECR, 16'd255);
    send_req(REQ_SPARE_6, 16'd4);
    send_req(REQ_SPARE_7, 16'hAAAA);
    send_req(pfar_pkg::REQ_FREE, 16'd300);
    // sender holds off until everything is back
    drain();
    set_bounds(16'hFFFF, 17'h10000);
    send_req(pfar_pkg::REQ_INIT, 16'hFFFF);
    send_req(pfar_pkg::REQ_INIT, 16'hFFFE);
    drain();
    set_bounds(16'd0, 17'd1);
    send_req(pfar_pkg::REQ_INIT, 16'd0);
    send_req(pfar_pkg::REQ_FREE, 16'd1);
    send_req(pfar_pkg::REQ_ALLOC, 16'h5555);
    send_req(pfar_pkg::REQ_GET, 16'h5555);
    drain();

    // random, sender idles less than receiver
    set_bounds(16'd8, 17'd40);
    run_mixed(200, 16'h0000);
    drain();

    // random near the top of the page range, idling swapped
    send_idle_pct  = 57;
    recv_stall_pct = 24;
    set_bounds(16'hFFE8, 17'h10000);
    run_mixed(200, 16'hFFE0);
    drain();

    // no idling: count saturation, then random
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_bounds(16'd0, 17'd32);
    sat_page = PAGE_W'($urandom_range(31));
    repeat (256) send_req(pfar_pkg::REQ_INCR, sat_page);
    send_req(pfar_pkg::REQ_GET, sat_page);
    send_req(pfar_pkg::REQ_FREE, sat_page);
    run_mixed(200, 16'h0000);
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/pfar_pkg.sv
rtl/core/pfar_ram.sv
rtl/core/pfar_queue.sv
rtl/core/pfar_front.sv
rtl/core/pfar_back.sv
rtl/core/page_frame_allocator_refcount.sv
sim/pfar_result_checker.sv
sim/tb_page_frame_allocator_refcount.sv
